// ===== rtl/apq_pkg.sv =====
// Shared types and codes for the aging priority queue.
`timescale 1ns / 1ps
package apq_pkg;

  localparam int ID_W   = 16;
  localparam int PRIO_W = 8;
  localparam int OP_W   = 2;
  localparam int ST_W   = 3;

  // Validity limits for an insert, one bit wider than the fields they bound.
  localparam logic [ID_W:0]   ID_MAX   = 17'd65535;
  localparam logic [PRIO_W:0] PRIO_MAX = 9'd255;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_RETRIEVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL       = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY      = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY_DONE = 3'd3;
  localparam logic [ST_W-1:0] ST_INVALID    = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic              ins;
    logic              ret;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

endpackage

// ===== rtl/aging_priority_queue_top.sv =====
// Top level of the aging priority queue: command decode, cell row and result register.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid, in_stall   | op, item_id, item_prio
//  output  | out_valid, out_stall | out_id, status, occupancy, is_empty, is_full
//
// The result of each transfer is registered and shows on the next cycle.
// The row of DEPTH cells compares, inserts and shifts in parallel, so one
// priority compare and the entry select in a cell set the cycle; nothing
// ripples from cell to cell.
// rst is synchronous; no clearing pass is needed after it.
// in_stall rises while a result is held and out_stall is high.
`timescale 1ns / 1ps
module aging_priority_queue_top import apq_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   op,
  input  logic [ID_W-1:0]   item_id,
  input  logic [PRIO_W-1:0] item_prio,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ID_W-1:0]   out_id,
  output logic [ST_W-1:0]   status,
  output logic [CNT_W-1:0]  occupancy,
  output logic              is_empty,
  output logic              is_full
);

  logic             accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             finished;
  logic             finished_next;
  logic [ST_W-1:0]  status_next;
  logic [ID_W-1:0]  out_id_next;
  logic             bad_item;
  cmd_t             cmd;

  entry_t ents [DEPTH];
  logic   ge   [DEPTH];
  logic   live [DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign bad_item = ({1'b0, item_id} > ID_MAX) || (item_prio == '0) ||
                    ({1'b0, item_prio} > PRIO_MAX);

  always_comb begin
    cmd           = '{ins: 1'b0, ret: 1'b0, id: item_id, prio: item_prio};
    count_next    = count;
    finished_next = finished;
    status_next   = ST_OK;
    out_id_next   = '0;
    case (op)
      OP_INSERT: begin
        if (bad_item) begin
          status_next = ST_INVALID;
        end else if (count == CNT_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          cmd.ins    = accept;
          count_next = count + CNT_W'(1);
        end
      end
      OP_RETRIEVE: begin
        if (count == '0) begin
          status_next = finished ? ST_EMPTY_DONE : ST_EMPTY;
        end else begin
          cmd.ret     = accept;
          out_id_next = ents[0].id;
          count_next  = count - CNT_W'(1);
        end
      end
      OP_FINISH: begin
        finished_next = 1'b1;
      end
      default: begin
        status_next = ST_INVALID;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t p_ent;
      entry_t n_ent;
      logic   p_ge;

      assign live[gi] = count > CNT_W'(gi);

      if (gi == 0) begin : g_head
        assign p_ent = '0;
        assign p_ge  = 1'b0;
      end else begin : g_body
        assign p_ent = ents[gi-1];
        assign p_ge  = ge[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign n_ent = '0;
      end else begin : g_mid
        assign n_ent = ents[gi+1];
      end

      apq_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .live     (live[gi]),
        .prev_ge  (p_ge),
        .prev_ent (p_ent),
        .next_ent (n_ent),
        .ent      (ents[gi]),
        .ge       (ge[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      finished  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        finished <= finished_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; load on each input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_id    <= out_id_next;
      status    <= status_next;
      occupancy <= count_next;
      is_empty  <= (count_next == '0);
      is_full   <= (count_next == CNT_W'(DEPTH));
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above DEPTH");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    live[1] |-> (ents[0].prio <= ents[1].prio))
    else $error("head entry out of order");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_RETRIEVE && count == '0) |=>
      (out_valid && (status == ST_EMPTY || status == ST_EMPTY_DONE) && out_id == '0))
    else $error("retrieve on empty queue gave wrong result");

  a_finish_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finished flag dropped");
`endif

endmodule

// ===== rtl/apq_cell.sv =====
// One slot of the sorted queue: holds an entry, inserts or shifts with its neighbors.
`timescale 1ns / 1ps
module apq_cell import apq_pkg::*; (
  input  logic   clk,
  input  cmd_t   cmd,
  input  logic   live,
  input  logic   prev_ge,
  input  entry_t prev_ent,
  input  entry_t next_ent,
  output entry_t ent,
  output logic   ge
);

  logic [PRIO_W-1:0] aged_prio;

  // The new entry belongs at or ahead of this slot.
  assign ge = !live || (ent.prio > cmd.prio);

  // Age the entry moving toward the head, floor at one.
  assign aged_prio = (next_ent.prio > PRIO_W'(1)) ? next_ent.prio - PRIO_W'(1)
                                                  : next_ent.prio;

  always_ff @(posedge clk) begin
    if (cmd.ins && ge) begin
      if (prev_ge) begin
        ent <= prev_ent;
      end else begin
        ent <= '{id: cmd.id, prio: cmd.prio};
      end
    end else if (cmd.ret) begin
      ent <= '{id: next_ent.id, prio: aged_prio};
    end
  end

endmodule

// ===== test/aging_priority_queue_top_checker.sv =====
// Checker for the aging priority queue: predicts every result and compares it on transfer.
`timescale 1ns / 1ps
module aging_priority_queue_top_checker import apq_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [OP_W-1:0]   op,
  input  logic [ID_W-1:0]   item_id,
  input  logic [PRIO_W-1:0] item_prio,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ID_W-1:0]   out_id,
  input  logic [ST_W-1:0]   status,
  input  logic [CNT_W-1:0]  occupancy,
  input  logic              is_empty,
  input  logic              is_full,
  output int                mismatches,
  output int                awaiting
);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [ST_W-1:0]  st;
    logic [CNT_W-1:0] occ;
    logic             empty;
    logic             full;
  } outcome_t;

  // Entries in leaving order: lowest priority number first, ties by arrival.
  entry_t   ordered_entries[$];
  logic     done_flag = 1'b0;
  outcome_t due_results[$];
  int       fault_count = 0;

  function automatic outcome_t serve_command(input logic [OP_W-1:0]   cmd,
                                             input logic [ID_W-1:0]   id,
                                             input logic [PRIO_W-1:0] pr);
    outcome_t res;
    entry_t   fresh;
    int       slot;
    res    = '0;
    res.st = ST_OK;
    case (cmd)
      OP_INSERT: begin
        if (pr == '0 || {1'b0, pr} > PRIO_MAX || {1'b0, id} > ID_MAX) begin
          res.st = ST_INVALID;
        end else if (ordered_entries.size() >= DEPTH) begin
          res.st = ST_FULL;
        end else begin
          fresh.id   = id;
          fresh.prio = pr;
          // go behind every entry of equal or lower number
          slot = 0;
          while (slot < ordered_entries.size() && ordered_entries[slot].prio <= pr)
            slot++;
          ordered_entries.insert(slot, fresh);
        end
      end
      OP_RETRIEVE: begin
        if (ordered_entries.size() == 0) begin
          res.st = done_flag ? ST_EMPTY_DONE : ST_EMPTY;
        end else begin
          fresh  = ordered_entries.pop_front();
          res.id = fresh.id;
          // age the rest; order is kept since all numbers above 1 drop together
          for (int i = 0; i < ordered_entries.size(); i++) begin
            fresh = ordered_entries[i];
            if (fresh.prio > 1) begin
              fresh.prio = fresh.prio - 1'b1;
              ordered_entries[i] = fresh;
            end
          end
        end
      end
      OP_FINISH: begin
        done_flag = 1'b1;
      end
      default: begin
        res.st = ST_INVALID;
      end
    endcase
    res.occ   = CNT_W'(ordered_entries.size());
    res.empty = (ordered_entries.size() == 0);
    res.full  = (ordered_entries.size() == DEPTH);
    return res;
  endfunction

  task automatic log_fault(input string what, input outcome_t want, input outcome_t seen);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected id=%h status=%0d occupancy=%0d empty=%b full=%b",
               want.id, want.st, want.occ, want.empty, want.full);
      $display("  actual   id=%h status=%0d occupancy=%0d empty=%b full=%b",
               seen.id, seen.st, seen.occ, seen.empty, seen.full);
    end
  endtask

  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (rst) begin
      ordered_entries.delete();
      due_results.delete();
      done_flag = 1'b0;
    end else begin
      // compare first: a result leaving now belongs to an earlier transfer
      if (out_valid && !out_stall) begin
        seen = {out_id, status, occupancy, is_empty, is_full};
        if (due_results.size() == 0) begin
          log_fault("result with nothing pending", '0, seen);
        end else begin
          want = due_results.pop_front();
          if (seen !== want) log_fault("result mismatch", want, seen);
        end
      end
      if (in_valid && !in_stall)
        due_results.push_back(serve_command(op, item_id, item_prio));
    end
    awaiting   <= due_results.size();
    mismatches <= fault_count;
  end

endmodule

// ===== test/aging_priority_queue_top_test.sv =====
// Testbench top for the aging priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module aging_priority_queue_top_test;
  import apq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1500;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   op;
  logic [ID_W-1:0]   item_id;
  logic [PRIO_W-1:0] item_prio;
  logic              out_valid;
  logic              out_stall;
  logic [ID_W-1:0]   out_id;
  logic [ST_W-1:0]   status;
  logic [CNT_W-1:0]  occupancy;
  logic              is_empty;
  logic              is_full;
  logic              calm;
  int                mismatches;
  int                awaiting;

  aging_priority_queue_top #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .item_id   (item_id),
    .item_prio (item_prio),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_id    (out_id),
    .status    (status),
    .occupancy (occupancy),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

  aging_priority_queue_top_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .item_id    (item_id),
    .item_prio  (item_prio),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_id     (out_id),
    .status     (status),
    .occupancy  (occupancy),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("aging_priority_queue_top_test NOT OK");
    $finish;
  end

  // Receiver side: stall at random except during the calm stretch.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = !calm && ($urandom_range(99) < 38);
    end
  end

  // Present one command and hold it until the transfer; return at the next falling edge.
  task automatic push_cmd(input logic [OP_W-1:0]   cmd,
                          input logic [ID_W-1:0]   id,
                          input logic [PRIO_W-1:0] pr);
    logic stalled;
    while (!calm && $urandom_range(99) < 38) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    op        = cmd;
    item_id   = id;
    item_prio = pr;
    // sample the stall just ahead of the rising edge, where it is settled
    do begin
      #5 stalled = in_stall;
      @(posedge clk);
      @(negedge clk);
    end while (stalled);
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 70) return PRIO_W'($urandom_range(8, 1));
    return PRIO_W'($urandom_range(255, 1));
  endfunction

  initial begin
    int insert_bias;
    int roll;
    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = OP_INSERT;
    item_id   = '0;
    item_prio = '0;
    calm      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty queue, unused code, zero priority
    push_cmd(OP_RETRIEVE, 16'hffff, 8'hff);
    push_cmd(OP_UNUSED, 16'hffff, 8'hff);
    push_cmd(OP_INSERT, 16'h1234, 8'd0);
    // field extremes, ties and reordering
    push_cmd(OP_INSERT, 16'hffff, 8'd255);
    push_cmd(OP_INSERT, 16'h0000, 8'd1);
    push_cmd(OP_INSERT, 16'h0101, 8'd3);
    push_cmd(OP_INSERT, 16'h0202, 8'd3);
    push_cmd(OP_INSERT, 16'h0303, 8'd2);
    // retrieve ages the rest, then inserts land behind aged entries of equal number
    push_cmd(OP_RETRIEVE, 16'h0000, 8'd0);
    push_cmd(OP_INSERT, 16'h0404, 8'd2);
    push_cmd(OP_INSERT, 16'h0505, 8'd1);
    repeat (7) push_cmd(OP_RETRIEVE, 16'h0000, 8'd0);
    // done flag, repeated, then empty and finished
    push_cmd(OP_FINISH, 16'h0000, 8'd0);
    push_cmd(OP_FINISH, 16'hffff, 8'hff);
    push_cmd(OP_RETRIEVE, 16'h0000, 8'd0);

    insert_bias = 80;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // swing between filling and draining so both full and empty are reached
      if (n % 100 == 0) begin
        case ($urandom_range(2))
          0:       insert_bias = 85;
          1:       insert_bias = 50;
          default: insert_bias = 20;
        endcase
      end
      calm = (n >= 600 && n < 900);
      roll = $urandom_range(99);
      if (roll < 4)
        push_cmd($urandom_range(1) ? OP_FINISH : OP_UNUSED, ID_W'($urandom),
                 PRIO_W'($urandom));
      else if ($urandom_range(99) < insert_bias)
        push_cmd(OP_INSERT, ID_W'($urandom), pick_prio());
      else
        push_cmd(OP_RETRIEVE, ID_W'($urandom), PRIO_W'($urandom));
    end
    in_valid = 1'b0;
    calm     = 1'b0;

    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("aging_priority_queue_top_test OK");
    end else begin
      $display("aging_priority_queue_top_test NOT OK");
    end
    $finish;
  end

endmodule
